// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the heap sort engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, sampled on clk, disabled during reset.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

// ===== rtl/hse_pkg.sv =====
// Shared constants, types and datapath command codes of the heap sort engine.
package hse_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = ADDR_W + 2;
    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [CNT_W-1:0]          count_t;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_READ_K,
        OP_SIFT_START,
        OP_SIFT_READ,
        OP_SIFT_CMP,
        OP_NEXT_BUILD,
        OP_NEXT_EXT,
        OP_EXT_READ,
        OP_EXT_LOAD,
        OP_OUT_READ,
        OP_OUT_LOAD,
        OP_OUT_POP
    } op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic multi;    // batch holds two or more values after this load
        logic leaf;     // sift position has no child inside the heap
        logic descend;  // larger child beats the sifted value
        logic k_zero;   // index counter is zero
        logic k_one;    // index counter is one
        logic out_last; // held result is the final one of the batch
    } stat_t;

endpackage

// ===== rtl/heap_sort_engine.sv =====
// Top level of the heap sort engine: controller and datapath.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata = value, s_tlast = last
// m_*      out  m_tvalid/m_tready  m_tdata = sorted_value, m_tlast = last_out,
//                                  m_tuser = overflow
//
// Loading accepts one request per cycle. After the last request the batch of n
// values is sorted: each sift reads both children through the registered RAM
// read, then compares; it descends one heap level at each compare that the
// larger child wins and ends at a leaf or a lost compare. Each result is then
// read from the heap, registered and held until the output takes it.
// No request is taken while a batch is sorted or emitted; reset (rst_n low)
// empties the batch, and the heap RAM needs no clearing pass.
module heap_sort_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser   // [0] overflow
);
    import hse_pkg::*;

    op_t    cmd;
    stat_t  stat;
    value_t out_data;

    hse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hse_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_value (value_t'(s_tdata)),
        .in_last  (s_tlast),
        .out_data (out_data),
        .out_last (m_tlast),
        .out_ovf  (m_tuser)
    );

    assign m_tdata = out_data;

endmodule

// ===== rtl/hse_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module hse_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    output logic [WIDTH-1:0] rdata0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/hse_datapath.sv =====
// Heap sort datapath: heap RAM, counters, sift compare and result register.
`include "assert_macros.svh"
module hse_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  hse_pkg::op_t   cmd,
    output hse_pkg::stat_t stat,
    input  hse_pkg::value_t in_value,
    input  logic           in_last,
    output hse_pkg::value_t out_data,
    output logic           out_last,
    output logic           out_ovf
);
    import hse_pkg::*;

    count_t cnt_reg, cnt_next;
    logic   ovf_reg, ovf_next;
    count_t len_reg, len_next;
    addr_t  k_reg, k_next;
    addr_t  pos_reg, pos_next;
    value_t val_reg, val_next;
    value_t out_data_reg, out_data_next;
    logic   out_last_reg, out_last_next;
    logic   out_ovf_reg, out_ovf_next;

    logic               we;
    addr_t              waddr, raddr0, raddr1;
    logic [VALUE_W-1:0] wdata, rdata0, rdata1;

    logic [CHILD_W-1:0] lc, rc, len_ext;
    logic               rc_ok, pick_rc, not_full, descend;
    count_t             cnt_inc;
    value_t             big_val;
    addr_t              big_idx;

    hse_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .rdata0 (rdata0),
        .raddr1 (raddr1),
        .rdata1 (rdata1)
    );

    // Child indexes and the larger-child compare
    always_comb
    begin
        lc       = {1'b0, pos_reg, 1'b1};
        rc       = {1'b0, pos_reg, 1'b0} + CHILD_W'(2);
        len_ext  = CHILD_W'(len_reg);
        rc_ok    = rc < len_ext;
        pick_rc  = rc_ok && ($signed(rdata1) > $signed(rdata0));
        big_val  = pick_rc ? value_t'(rdata1) : value_t'(rdata0);
        big_idx  = pick_rc ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
        descend  = big_val > val_reg;
        not_full = cnt_reg < CNT_W'(DEPTH);
        cnt_inc  = not_full ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // Status toward the controller
    always_comb
    begin
        stat.multi    = cnt_inc >= CNT_W'(2);
        stat.leaf     = lc >= len_ext;
        stat.descend  = descend;
        stat.k_zero   = k_reg == '0;
        stat.k_one    = k_reg == ADDR_W'(1);
        stat.out_last = out_last_reg;
    end

    // RAM ports and register updates per command
    always_comb
    begin
        we            = 1'b0;
        waddr         = pos_reg;
        wdata         = val_reg;
        raddr0        = k_reg;
        raddr1        = k_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;
        case (cmd)
            OP_LOAD:
            begin
                if (not_full)
                begin
                    we    = 1'b1;
                    waddr = cnt_reg[ADDR_W-1:0];
                    wdata = in_value;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                cnt_next = cnt_inc;
                if (in_last)
                begin
                    len_next = cnt_inc;
                    k_next   = stat.multi ? ADDR_W'((cnt_inc >> 1) - CNT_W'(1)) : '0;
                end
            end
            OP_READ_K:
            begin
                raddr0 = k_reg;
            end
            OP_SIFT_START:
            begin
                val_next = value_t'(rdata0);
                pos_next = k_reg;
            end
            OP_SIFT_READ:
            begin
                raddr0 = lc[ADDR_W-1:0];
                raddr1 = rc_ok ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
                if (stat.leaf)
                begin
                    we = 1'b1;
                end
            end
            OP_SIFT_CMP:
            begin
                we = 1'b1;
                if (descend)
                begin
                    wdata    = big_val;
                    pos_next = big_idx;
                end
            end
            OP_NEXT_BUILD:
            begin
                k_next = stat.k_zero ? ADDR_W'(len_reg - CNT_W'(1)) : k_reg - ADDR_W'(1);
            end
            OP_NEXT_EXT:
            begin
                k_next = stat.k_one ? '0 : k_reg - ADDR_W'(1);
            end
            OP_EXT_READ:
            begin
                raddr0 = '0;
                raddr1 = k_reg;
            end
            OP_EXT_LOAD:
            begin
                // Swap root to the end, shrink the heap, sift the old tail
                we       = 1'b1;
                waddr    = k_reg;
                wdata    = rdata0;
                val_next = value_t'(rdata1);
                pos_next = '0;
                len_next = CNT_W'(k_reg);
            end
            OP_OUT_READ:
            begin
                raddr0 = k_reg;
            end
            OP_OUT_LOAD:
            begin
                out_data_next = value_t'(rdata0);
                out_last_next = (CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg;
                out_ovf_next  = ovf_reg;
            end
            OP_OUT_POP:
            begin
                if (out_last_reg)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
                else
                begin
                    k_next = k_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            len_reg      <= '0;
            k_reg        <= '0;
            pos_reg      <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            len_reg      <= len_next;
            k_reg        <= k_next;
            pos_reg      <= pos_next;
            out_last_reg <= out_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;
    assign out_ovf  = out_ovf_reg;

    `CHK_IMPL(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `CHK_NEXT(a_ovf_on_full, (cmd == OP_LOAD) && !not_full, ovf_reg)
    `CHK_NEXT(a_clear_after_batch, (cmd == OP_OUT_POP) && out_last_reg, (cnt_reg == '0) && !ovf_reg)

endmodule

// ===== rtl/hse_ctrl.sv =====
// Heap sort controller: load, heap build, extraction and output sequencing.
`include "assert_macros.svh"
module hse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_last,
    output logic           out_valid,
    input  logic           out_ready,
    output hse_pkg::op_t   cmd,
    input  hse_pkg::stat_t stat
);
    import hse_pkg::*;

    typedef enum logic [10:0] {
        ST_LOAD     = 11'b000_0000_0001,
        ST_BUILD_RD = 11'b000_0000_0010,
        ST_BUILD_LD = 11'b000_0000_0100,
        ST_SIFT_RD  = 11'b000_0000_1000,
        ST_SIFT_CMP = 11'b000_0001_0000,
        ST_NEXT     = 11'b000_0010_0000,
        ST_EXT_RD   = 11'b000_0100_0000,
        ST_EXT_LD   = 11'b000_1000_0000,
        ST_OUT_RD   = 11'b001_0000_0000,
        ST_OUT_LD   = 11'b010_0000_0000,
        ST_OUT_WAIT = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   build_reg, build_next;

    // Sequence the phases and issue one datapath command per cycle
    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        cmd        = OP_IDLE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = OP_LOAD;
                    if (in_last)
                    begin
                        build_next = 1'b1;
                        state_next = stat.multi ? ST_BUILD_RD : ST_OUT_RD;
                    end
                end
            end
            ST_BUILD_RD:
            begin
                cmd        = OP_READ_K;
                state_next = ST_BUILD_LD;
            end
            ST_BUILD_LD:
            begin
                cmd        = OP_SIFT_START;
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                cmd        = OP_SIFT_READ;
                state_next = stat.leaf ? ST_NEXT : ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                cmd        = OP_SIFT_CMP;
                state_next = stat.descend ? ST_SIFT_RD : ST_NEXT;
            end
            ST_NEXT:
            begin
                if (build_reg)
                begin
                    cmd = OP_NEXT_BUILD;
                    if (stat.k_zero)
                    begin
                        build_next = 1'b0;
                        state_next = ST_EXT_RD;
                    end
                    else
                    begin
                        state_next = ST_BUILD_RD;
                    end
                end
                else
                begin
                    cmd        = OP_NEXT_EXT;
                    state_next = stat.k_one ? ST_OUT_RD : ST_EXT_RD;
                end
            end
            ST_EXT_RD:
            begin
                cmd        = OP_EXT_READ;
                state_next = ST_EXT_LD;
            end
            ST_EXT_LD:
            begin
                cmd        = OP_EXT_LOAD;
                state_next = ST_SIFT_RD;
            end
            ST_OUT_RD:
            begin
                cmd        = OP_OUT_READ;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                cmd        = OP_OUT_LOAD;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd        = OP_OUT_POP;
                    state_next = stat.out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    `CHK_IMPL(a_cmp_after_read, state_reg == ST_SIFT_CMP, $past(state_reg) == ST_SIFT_RD)

endmodule
